@@ design/time_of_day_calendar_counter_assert.svh @@
// Assertion macros used by the calendar counter checker.
`ifndef TIME_OF_DAY_CALENDAR_COUNTER_ASSERT_SVH
`define TIME_OF_DAY_CALENDAR_COUNTER_ASSERT_SVH

// Clocked assertion, masked while reset is high.
`define TODCAL_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define TODCAL_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/todcal_pkg.sv @@
`timescale 1ns / 1ps

package todcal_pkg;

   // Current date and time.
   typedef struct packed {
      logic [5:0]  seconds;
      logic [5:0]  minutes;
      logic [4:0]  hours;
      logic [4:0]  day;
      logic [3:0]  month;
      logic [13:0] year;
   } cal_type;

   localparam logic [15:0] TPS_RESET = 16'd1000;

   localparam logic [5:0]  SEC_MAX   = 6'd59;
   localparam logic [5:0]  MIN_MAX   = 6'd59;
   localparam logic [4:0]  HOUR_MAX  = 5'd23;
   localparam logic [4:0]  DAY_MIN   = 5'd1;
   localparam logic [4:0]  DAY_MAX   = 5'd31;
   localparam logic [3:0]  MONTH_MIN = 4'd1;
   localparam logic [3:0]  MONTH_MAX = 4'd12;
   localparam logic [13:0] YEAR_MAX  = 14'd9999;

   localparam cal_type CAL_RESET = '{
      seconds: 6'd0,
      minutes: 6'd10,
      hours:   5'd6,
      day:     5'd25,
      month:   4'd3,
      year:    14'd2015
   };

   // Adjust command letters: lower case steps down, upper case steps up.
   localparam logic [7:0] CMD_HOUR_DN  = 8'h68; // h
   localparam logic [7:0] CMD_HOUR_UP  = 8'h48; // H
   localparam logic [7:0] CMD_MIN_DN   = 8'h6D; // m
   localparam logic [7:0] CMD_MIN_UP   = 8'h4D; // M
   localparam logic [7:0] CMD_SEC_DN   = 8'h73; // s
   localparam logic [7:0] CMD_SEC_UP   = 8'h53; // S
   localparam logic [7:0] CMD_DAY_DN   = 8'h64; // d
   localparam logic [7:0] CMD_DAY_UP   = 8'h44; // D
   localparam logic [7:0] CMD_MONTH_DN = 8'h65; // e
   localparam logic [7:0] CMD_MONTH_UP = 8'h45; // E
   localparam logic [7:0] CMD_YEAR_DN  = 8'h61; // a
   localparam logic [7:0] CMD_YEAR_UP  = 8'h41; // A

endpackage

@@ design/time_of_day_calendar_counter.sv @@
`timescale 1ns / 1ps

// Real-time clock and calendar. Each request word is either one tick
// (req_mode = 0) or an adjust letter (req_mode = 1, req_command_byte):
// h/H hour, m/M minute, s/S second, d/D day, e/E month, a/A year, lower case
// steps the field down and upper case steps it up, saturating at the field's
// bounds; other letters are ignored. Ticks are counted until csr ticks per
// second (reset 1000) of them have arrived, then the second advances and
// carries through minute, hour, day, month and year. Every month has 31 days,
// and the year holds at 9999. Every request word gives one response word with
// the date and time after the update, plus rsp_second_elapsed on a tick that
// completed a second. Throughput is one word per clock while rsp_stall is low;
// a request is accepted into the input register, then carried through the
// calendar update into the response register, where the response word is
// valid. The update reads and writes the calendar state as the response word
// is loaded, so consecutive words chain with no gap. Write csr only
// while no word is in flight.
module time_of_day_calendar_counter import todcal_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  logic [7:0]  req_command_byte,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [5:0]  rsp_seconds,
   output logic [5:0]  rsp_minutes,
   output logic [4:0]  rsp_hours,
   output logic [4:0]  rsp_day,
   output logic [3:0]  rsp_month,
   output logic [13:0] rsp_year,
   output logic        rsp_second_elapsed,
   // ticks per second register
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data
);

   // architectural state
   logic [15:0] tps_ff;
   logic [15:0] ticks_ff;
   cal_type     cal_ff;

   // input register
   logic        in_valid_ff;
   logic        in_mode_ff;
   logic [7:0]  in_cmd_ff;

   // response register
   logic        rsp_valid_ff;
   cal_type     rsp_cal_ff;
   logic        rsp_elapsed_ff;

   // update results
   cal_type     cal_in;
   logic [15:0] ticks_in;
   logic        elapsed_in;

   logic        advance;
   logic        fire;
   logic        req_take;

   // Move the input word on when the response register is empty or draining.
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   todcal_update u_update (
      .cur_cal          (cal_ff),
      .cur_ticks        (ticks_ff),
      .ticks_per_second (tps_ff),
      .mode             (in_mode_ff),
      .command_byte     (in_cmd_ff),
      .nxt_cal          (cal_in),
      .nxt_ticks        (ticks_in),
      .second_elapsed   (elapsed_in)
   );

   // Control and calendar state.
   always_ff @(posedge clock) begin
      if (reset) begin
         tps_ff       <= TPS_RESET;
         ticks_ff     <= '0;
         cal_ff       <= CAL_RESET;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            tps_ff <= csr_write_data;
         end
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= in_valid_ff;
         end
         // commit the update together with its response word
         if (fire) begin
            ticks_ff <= ticks_in;
            cal_ff   <= cal_in;
         end
      end
   end

   // Payload registers: hold while stalled.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_mode_ff <= req_mode;
         in_cmd_ff  <= req_command_byte;
      end
      if (fire) begin
         rsp_cal_ff     <= cal_in;
         rsp_elapsed_ff <= elapsed_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_seconds        = rsp_cal_ff.seconds;
   assign rsp_minutes        = rsp_cal_ff.minutes;
   assign rsp_hours          = rsp_cal_ff.hours;
   assign rsp_day            = rsp_cal_ff.day;
   assign rsp_month          = rsp_cal_ff.month;
   assign rsp_year           = rsp_cal_ff.year;
   assign rsp_second_elapsed = rsp_elapsed_ff;

endmodule

@@ design/todcal_update.sv @@
`timescale 1ns / 1ps

// Next-state logic for one word: tick counting, second cascade, adjust commands.
module todcal_update import todcal_pkg::*; (
   input  cal_type     cur_cal,
   input  logic [15:0] cur_ticks,
   input  logic [15:0] ticks_per_second,
   input  logic        mode,
   input  logic [7:0]  command_byte,
   output cal_type     nxt_cal,
   output logic [15:0] nxt_ticks,
   output logic        second_elapsed
);

   logic [16:0] tick_sum;

   assign tick_sum = {1'b0, cur_ticks} + 17'd1;

   always_comb begin
      nxt_cal        = cur_cal;
      nxt_ticks      = cur_ticks;
      second_elapsed = 1'b0;
      if (!mode) begin
         if (tick_sum >= {1'b0, ticks_per_second}) begin
            nxt_ticks      = '0;
            second_elapsed = 1'b1;
            // ripple the carry up through the fields
            if (cur_cal.seconds < SEC_MAX) begin
               nxt_cal.seconds = cur_cal.seconds + 6'd1;
            end else begin
               nxt_cal.seconds = '0;
               if (cur_cal.minutes < MIN_MAX) begin
                  nxt_cal.minutes = cur_cal.minutes + 6'd1;
               end else begin
                  nxt_cal.minutes = '0;
                  if (cur_cal.hours < HOUR_MAX) begin
                     nxt_cal.hours = cur_cal.hours + 5'd1;
                  end else begin
                     nxt_cal.hours = '0;
                     if (cur_cal.day < DAY_MAX) begin
                        nxt_cal.day = cur_cal.day + 5'd1;
                     end else begin
                        nxt_cal.day = DAY_MIN;
                        if (cur_cal.month < MONTH_MAX) begin
                           nxt_cal.month = cur_cal.month + 4'd1;
                        end else begin
                           nxt_cal.month = MONTH_MIN;
                           // hold the year at its top value
                           if (cur_cal.year < YEAR_MAX) begin
                              nxt_cal.year = cur_cal.year + 14'd1;
                           end
                        end
                     end
                  end
               end
            end
         end else begin
            nxt_ticks = tick_sum[15:0];
         end
      end else begin
         // saturate at the field bounds, no carry or borrow
         unique case (command_byte)
            CMD_HOUR_DN: begin
               if (cur_cal.hours > 5'd0) nxt_cal.hours = cur_cal.hours - 5'd1;
            end
            CMD_HOUR_UP: begin
               if (cur_cal.hours < HOUR_MAX) nxt_cal.hours = cur_cal.hours + 5'd1;
            end
            CMD_MIN_DN: begin
               if (cur_cal.minutes > 6'd0) nxt_cal.minutes = cur_cal.minutes - 6'd1;
            end
            CMD_MIN_UP: begin
               if (cur_cal.minutes < MIN_MAX) nxt_cal.minutes = cur_cal.minutes + 6'd1;
            end
            CMD_SEC_DN: begin
               if (cur_cal.seconds > 6'd0) nxt_cal.seconds = cur_cal.seconds - 6'd1;
            end
            CMD_SEC_UP: begin
               if (cur_cal.seconds < SEC_MAX) nxt_cal.seconds = cur_cal.seconds + 6'd1;
            end
            CMD_DAY_DN: begin
               if (cur_cal.day > DAY_MIN) nxt_cal.day = cur_cal.day - 5'd1;
            end
            CMD_DAY_UP: begin
               if (cur_cal.day < DAY_MAX) nxt_cal.day = cur_cal.day + 5'd1;
            end
            CMD_MONTH_DN: begin
               if (cur_cal.month > MONTH_MIN) nxt_cal.month = cur_cal.month - 4'd1;
            end
            CMD_MONTH_UP: begin
               if (cur_cal.month < MONTH_MAX) nxt_cal.month = cur_cal.month + 4'd1;
            end
            CMD_YEAR_DN: begin
               if (cur_cal.year > 14'd0) nxt_cal.year = cur_cal.year - 14'd1;
            end
            CMD_YEAR_UP: begin
               if (cur_cal.year < YEAR_MAX) nxt_cal.year = cur_cal.year + 14'd1;
            end
            default: begin
               // drop unknown letters
            end
         endcase
      end
   end

endmodule

@@ design/todcal_checker.sv @@
`timescale 1ns / 1ps

`include "time_of_day_calendar_counter_assert.svh"

// Port-level checks on the calendar counter.
module todcal_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [5:0]  rsp_seconds,
   input logic [5:0]  rsp_minutes,
   input logic [4:0]  rsp_hours,
   input logic [4:0]  rsp_day,
   input logic [3:0]  rsp_month,
   input logic [13:0] rsp_year,
   input logic        rsp_second_elapsed
);

   logic [39:0] rsp_word;
   logic        rsp_in_range;

   assign rsp_word = {rsp_seconds, rsp_minutes, rsp_hours, rsp_day, rsp_month, rsp_year};

   assign rsp_in_range = (rsp_seconds <= 6'd59) && (rsp_minutes <= 6'd59) &&
                         (rsp_hours <= 5'd23) && (rsp_day >= 5'd1) && (rsp_day <= 5'd31) &&
                         (rsp_month >= 4'd1) && (rsp_month <= 4'd12) &&
                         (rsp_year <= 14'd9999);

   `TODCAL_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "response valid after reset")

   `TODCAL_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word) && $stable(rsp_second_elapsed), "stalled response word changed")

   `TODCAL_ASSERT(a_rsp_range, clock, reset, rsp_valid |-> rsp_in_range, "calendar field out of range")

   `TODCAL_ASSERT(a_no_stall_when_empty, clock, reset, !rsp_valid |-> !req_stall, "request stalled with empty response register")

endmodule

bind time_of_day_calendar_counter todcal_checker u_todcal_checker (
   .clock              (clock),
   .reset              (reset),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_seconds        (rsp_seconds),
   .rsp_minutes        (rsp_minutes),
   .rsp_hours          (rsp_hours),
   .rsp_day            (rsp_day),
   .rsp_month          (rsp_month),
   .rsp_year           (rsp_year),
   .rsp_second_elapsed (rsp_second_elapsed)
);
